[rtl/brp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// brp_pkg: shared definitions of the byte range partitioner
// Alphabet size, sweep geometry and the command word that the front end
// queues for the back end.
// ----------------------------------------------------------------------------
package brp_pkg;

    // Alphabet and field widths
    localparam int ALPHABET_SIZE = 256;
    localparam int BYTE_W        = 8;
    localparam int BYTE_SPAN     = 1 << BYTE_W;
    localparam int COUNT_W       = BYTE_W + 1;

    // Sweep geometry: the start and end maps are scanned one chunk a cycle
    localparam int CHUNK_W  = 16;
    localparam int NCHUNK   = (ALPHABET_SIZE + CHUNK_W - 1) / CHUNK_W;
    localparam int MAP_W    = NCHUNK * CHUNK_W;
    localparam int CIDX_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int POPCNT_W = $clog2(CHUNK_W + 1);

    // Command classes decided by the front end
    typedef enum logic [1:0] {
        OP_INSERT,
        OP_LOOKUP,
        OP_BAD,
        OP_SKIP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] last;
        logic [BYTE_W-1:0] probe;
    } cmd_t;

endpackage : brp_pkg
`default_nettype wire

[rtl/brp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// brp_front: input classifier and command queue
// Accepts input beats, clips and classifies them, and holds up to two
// commands for the back end.
// ----------------------------------------------------------------------------
module brp_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  func,
    input  wire logic [7:0]            range_first,
    input  wire logic [7:0]            range_last,
    input  wire logic [7:0]            probe_byte,
    output logic                       cmd_valid,
    output brp_pkg::cmd_t              cmd,
    input  wire logic                  cmd_pop
);
    import brp_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       entry_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    cmd_t              cmd_in;
    logic [BYTE_W-1:0] last_clip;
    logic              push;
    logic              pop;

    // Clip the end of the range to the alphabet and classify the beat
    always_comb
    begin
        if ({1'b0, range_last} >= COUNT_W'(ALPHABET_SIZE))
            last_clip = BYTE_W'(ALPHABET_SIZE - 1);
        else
            last_clip = range_last;

        cmd_in.first = range_first;
        cmd_in.last  = last_clip;
        cmd_in.probe = probe_byte;
        if (func)
            cmd_in.op = OP_LOOKUP;
        else if (range_first > range_last)
            cmd_in.op = OP_BAD;
        else if (range_first > last_clip)
            cmd_in.op = OP_SKIP;
        else
            cmd_in.op = OP_INSERT;
    end

    // Queue control
    assign in_stall  = (count_reg == 2'(DEPTH));
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= cmd_in;
    end

    // Occupancy agrees with the pointers
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with occupancy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with single entry");

    // Occupancy never exceeds the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= 2'(DEPTH)))
        else $error("queue overfilled");

endmodule : brp_front
`default_nettype wire

[rtl/brp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// brp_back: partition maps and sweep engine
// Holds the covered and cut maps, applies inserts, then sweeps the range
// start and end maps chunk by chunk to form the result beat.
// ----------------------------------------------------------------------------
module brp_back
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    input  wire brp_pkg::cmd_t         cmd,
    output logic                       cmd_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       bad_range,
    output logic                       probe_covered,
    output logic [7:0]                 class_index,
    output logic [7:0]                 class_first,
    output logic [7:0]                 class_last,
    output logic [8:0]                 range_count
);
    import brp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    function automatic logic [POPCNT_W-1:0] popcount(input logic [CHUNK_W-1:0] v);
        logic [POPCNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < CHUNK_W; i++)
            n = n + POPCNT_W'(v[i]);
        return n;
    endfunction

    state_t state_reg, state_next;
    cmd_t   cur_reg, cur_next;

    logic [ALPHABET_SIZE-1:0] covered_reg, covered_next;
    logic [ALPHABET_SIZE-1:0] cut_reg, cut_next;

    logic [CIDX_W-1:0]  chunk_reg, chunk_next;
    logic [COUNT_W-1:0] count_all_reg, count_all_next;
    logic [COUNT_W-1:0] count_le_reg, count_le_next;
    logic [BYTE_W-1:0]  cf_reg, cf_next;
    logic [BYTE_W-1:0]  cl_reg, cl_next;
    logic               cl_found_reg, cl_found_next;

    logic               out_valid_reg, out_valid_next;
    logic               bad_reg, bad_next;
    logic               cov_reg, cov_next;
    logic [BYTE_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0]  first_reg, first_next;
    logic [BYTE_W-1:0]  last_reg, last_next;
    logic [COUNT_W-1:0] rcount_reg, rcount_next;

    logic [ALPHABET_SIZE-1:0] start_vec;
    logic [ALPHABET_SIZE-1:0] end_vec;
    logic [MAP_W-1:0]         start_pad;
    logic [MAP_W-1:0]         end_pad;
    logic [BYTE_SPAN-1:0]     covered_span;

    logic [CHUNK_W-1:0] s_chunk, e_chunk, le_mask, ge_mask, s_le, e_ge;
    logic [COUNT_W-1:0] pos [CHUNK_W];
    logic [BYTE_W-1:0]  cf_cand, cl_cand;
    logic [COUNT_W-1:0] probe_w;
    logic               probe_hit;
    logic               out_free;
    logic               last_chunk;

    // Derive range starts and ends from the maps
    always_comb
    begin
        for (int b = 0; b < ALPHABET_SIZE; b++)
        begin
            if (b == 0)
                start_vec[b] = covered_reg[b];
            else
                start_vec[b] = covered_reg[b] && (cut_reg[b] || !covered_reg[b-1]);
        end
        for (int b = 0; b < ALPHABET_SIZE; b++)
        begin
            if (b == ALPHABET_SIZE - 1)
                end_vec[b] = covered_reg[b];
            else
                end_vec[b] = covered_reg[b] && (!covered_reg[b+1] || start_vec[b+1]);
        end
    end

    assign start_pad    = MAP_W'(start_vec);
    assign end_pad      = MAP_W'(end_vec);
    assign covered_span = BYTE_SPAN'(covered_reg);
    assign probe_w      = {1'b0, cur_reg.probe};
    assign probe_hit    = covered_span[cur_reg.probe];

    // Select the current chunk and mask it against the probe
    always_comb
    begin
        s_chunk = start_pad[int'(chunk_reg) * CHUNK_W +: CHUNK_W];
        e_chunk = end_pad[int'(chunk_reg) * CHUNK_W +: CHUNK_W];
        for (int i = 0; i < CHUNK_W; i++)
        begin
            pos[i]     = COUNT_W'(int'(chunk_reg) * CHUNK_W + i);
            le_mask[i] = (pos[i] <= probe_w);
            ge_mask[i] = (pos[i] >= probe_w);
        end
        s_le = s_chunk & le_mask;
        e_ge = e_chunk & ge_mask;

        // Highest start at or below the probe
        cf_cand = cf_reg;
        for (int i = 0; i < CHUNK_W; i++)
        begin
            if (s_le[i])
                cf_cand = pos[i][BYTE_W-1:0];
        end
        // Lowest end at or above the probe
        cl_cand = cl_reg;
        for (int i = CHUNK_W - 1; i >= 0; i--)
        begin
            if (e_ge[i])
                cl_cand = pos[i][BYTE_W-1:0];
        end
    end

    assign last_chunk = (chunk_reg == CIDX_W'(NCHUNK - 1));
    assign out_free   = !out_valid_reg || !out_stall;
    assign cmd_pop    = (state_reg == ST_IDLE) && cmd_valid;

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        covered_next   = covered_reg;
        cut_next       = cut_reg;
        chunk_next     = chunk_reg;
        count_all_next = count_all_reg;
        count_le_next  = count_le_reg;
        cf_next        = cf_reg;
        cl_next        = cl_reg;
        cl_found_next  = cl_found_reg;
        out_valid_next = out_valid_reg;
        bad_next       = bad_reg;
        cov_next       = cov_reg;
        idx_next       = idx_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        rcount_next    = rcount_reg;

        // Drop the result once it is taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next       = cmd;
                    chunk_next     = '0;
                    count_all_next = '0;
                    count_le_next  = '0;
                    cf_next        = '0;
                    cl_next        = '0;
                    cl_found_next  = 1'b0;
                    state_next     = (cmd.op == OP_INSERT) ? ST_APPLY : ST_SWEEP;
                end
            end
            ST_APPLY:
            begin
                // Mark the range covered and cut at both of its edges
                for (int b = 0; b < ALPHABET_SIZE; b++)
                begin
                    if (b >= int'(cur_reg.first) && b <= int'(cur_reg.last))
                        covered_next[b] = 1'b1;
                    if (b == int'(cur_reg.first) || b == int'(cur_reg.last) + 1)
                        cut_next[b] = 1'b1;
                end
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                count_all_next = count_all_reg + COUNT_W'(popcount(s_chunk));
                count_le_next  = count_le_reg + COUNT_W'(popcount(s_le));
                cf_next        = cf_cand;
                if (!cl_found_reg && (e_ge != '0))
                begin
                    cl_next       = cl_cand;
                    cl_found_next = 1'b1;
                end
                if (last_chunk)
                    state_next = ST_FINISH;
                else
                    chunk_next = chunk_reg + CIDX_W'(1);
            end
            ST_FINISH:
            begin
                // Load the result beat once the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    bad_next       = (cur_reg.op == OP_BAD);
                    rcount_next    = count_all_reg;
                    if (cur_reg.op == OP_LOOKUP && probe_hit)
                    begin
                        cov_next   = 1'b1;
                        idx_next   = BYTE_W'(count_le_reg - COUNT_W'(1));
                        first_next = cf_reg;
                        last_next  = cl_reg;
                    end
                    else
                    begin
                        cov_next   = 1'b0;
                        idx_next   = '0;
                        first_next = '0;
                        last_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, maps and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            covered_reg   <= '0;
            cut_reg       <= '0;
            chunk_reg     <= '0;
            count_all_reg <= '0;
            count_le_reg  <= '0;
            cf_reg        <= '0;
            cl_reg        <= '0;
            cl_found_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bad_reg       <= 1'b0;
            cov_reg       <= 1'b0;
            idx_reg       <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            rcount_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            covered_reg   <= covered_next;
            cut_reg       <= cut_next;
            chunk_reg     <= chunk_next;
            count_all_reg <= count_all_next;
            count_le_reg  <= count_le_next;
            cf_reg        <= cf_next;
            cl_reg        <= cl_next;
            cl_found_reg  <= cl_found_next;
            out_valid_reg <= out_valid_next;
            bad_reg       <= bad_next;
            cov_reg       <= cov_next;
            idx_reg       <= idx_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            rcount_reg    <= rcount_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bad_range     = bad_reg;
    assign probe_covered = cov_reg;
    assign class_index   = idx_reg;
    assign class_first   = first_reg;
    assign class_last    = last_reg;
    assign range_count   = rcount_reg;

    // A new result appears only from the finishing step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finishing step");

    // The sweep runs to its last chunk without leaving early
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && !last_chunk) |=> (state_reg == ST_SWEEP))
        else $error("sweep left before its last chunk");

    // The covered map never loses bits
    assert property (@(posedge clk) disable iff (!rst_n)
        ((covered_reg & ~$past(covered_reg)) == (covered_reg ^ $past(covered_reg))))
        else $error("covered map lost a bit");

    // A flagged insert never reports coverage
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(bad_reg && cov_reg))
        else $error("result flags both bad range and coverage");

endmodule : brp_back
`default_nettype wire

[rtl/byte_range_partitioner.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// byte_range_partitioner: character class partition of the byte alphabet
//
// Input channel (in_valid / in_stall): one beat per item. func = 0 inserts
// the range range_first..range_last, func = 1 looks up probe_byte. A beat
// is taken whenever the two-entry command queue has room, so the sender
// only sees in_stall once two items are waiting behind the one at work.
// Output channel (out_valid / out_stall): one result beat per item, in
// order, held in an output register for as long as the receiver stalls;
// the back end waits at its finishing step until that register frees.
// Each item is carried out by a sweep over the range start and end maps,
// 16 bytes a cycle across the full alphabet. An insert first takes an
// extra step to write the maps. The back end takes the next item from
// the queue only after the finishing step has loaded the last result,
// so it works on one item at a time.
// Reset clears both maps, the queue and the output register at once.
// ----------------------------------------------------------------------------
module byte_range_partitioner
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       func,
    input  wire logic [7:0] range_first,
    input  wire logic [7:0] range_last,
    input  wire logic [7:0] probe_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            bad_range,
    output logic            probe_covered,
    output logic [7:0]      class_index,
    output logic [7:0]      class_first,
    output logic [7:0]      class_last,
    output logic [8:0]      range_count
);
    import brp_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // Classify and queue input beats
    brp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .range_first (range_first),
        .range_last  (range_last),
        .probe_byte  (probe_byte),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // Carry out commands against the maps
    brp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .bad_range     (bad_range),
        .probe_covered (probe_covered),
        .class_index   (class_index),
        .class_first   (class_first),
        .class_last    (class_last),
        .range_count   (range_count)
    );

endmodule : byte_range_partitioner
`default_nettype wire

[tb/byte_range_partitioner_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_range_partitioner_tb: self-checking bench for the byte range partitioner
// Feeds insert and lookup beats through a queue-driven driver, predicts each
// result from a local copy of the covered and cut maps, and checks every
// result beat in order. It runs directed corner cases, random phases under
// several idling patterns, one long output hold-off and a sweep that cuts the
// alphabet into single bytes.
// ----------------------------------------------------------------------------
module byte_range_partitioner_tb;

    import brp_pkg::ALPHABET_SIZE;
    import brp_pkg::BYTE_W;
    import brp_pkg::COUNT_W;

    localparam bit FUNC_INSERT = 1'b0;
    localparam bit FUNC_LOOKUP = 1'b1;
    localparam int TOP_BYTE    = ALPHABET_SIZE - 1;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] last;
        logic [BYTE_W-1:0] probe;
    } item_t;

    typedef struct packed {
        logic               bad;
        logic               covered;
        logic [BYTE_W-1:0]  index;
        logic [BYTE_W-1:0]  lo;
        logic [BYTE_W-1:0]  hi;
        logic [COUNT_W-1:0] count;
    } class_result_t;

    // DUT ports
    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic              func        = 1'b0;
    logic [7:0]        range_first = '0;
    logic [7:0]        range_last  = '0;
    logic [7:0]        probe_byte  = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic              bad_range;
    logic              probe_covered;
    logic [7:0]        class_index;
    logic [7:0]        class_first;
    logic [7:0]        class_last;
    logic [8:0]        range_count;

    // Predictor state: a private copy of both maps
    bit [ALPHABET_SIZE-1:0] covered_bytes;
    bit [ALPHABET_SIZE-1:0] cut_bytes;

    item_t         pending_items[$];
    class_result_t expected_classes[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_go        = 1'b0;
    bit  out_hold       = 1'b0;
    bit  in_fire        = 1'b0;

    int  mismatch_count = 0;
    int  checked_beats  = 0;
    int  insert_beats   = 0;
    int  lookup_beats   = 0;
    int  reversed_beats = 0;
    int  covered_hits   = 0;
    int  in_stall_cycles = 0;
    int  peak_count     = 0;

    byte_range_partitioner dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .range_first   (range_first),
        .range_last    (range_last),
        .probe_byte    (probe_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .bad_range     (bad_range),
        .probe_covered (probe_covered),
        .class_index   (class_index),
        .class_first   (class_first),
        .class_last    (class_last),
        .range_count   (range_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // A byte opens a range when covered and either cut or after a gap
    function automatic bit opens_range(int b);
        if (!covered_bytes[b])
            return 1'b0;
        if (b == 0 || cut_bytes[b])
            return 1'b1;
        return !covered_bytes[b-1];
    endfunction

    // Apply one beat to the local maps and work out its result
    function automatic class_result_t partition_step(item_t it);
        class_result_t r;
        int            b;
        int            lo;
        int            hi;
        int            idx;
        int            n;
        r = '0;
        if (it.func == FUNC_INSERT)
        begin
            if (it.first > it.last)
                r.bad = 1'b1;
            else
            begin
                for (b = it.first; b <= it.last; b++)
                    covered_bytes[b] = 1'b1;
                cut_bytes[it.first] = 1'b1;
                if (it.last < TOP_BYTE)
                    cut_bytes[it.last + 1] = 1'b1;
            end
        end
        else if (covered_bytes[it.probe])
        begin
            lo = it.probe;
            while (!opens_range(lo))
                lo--;
            hi = it.probe;
            while (hi < TOP_BYTE && !opens_range(hi + 1) && covered_bytes[hi + 1])
                hi++;
            idx = 0;
            for (b = 0; b < lo; b++)
                idx += opens_range(b);
            r.covered = 1'b1;
            r.index   = idx[BYTE_W-1:0];
            r.lo      = lo[BYTE_W-1:0];
            r.hi      = hi[BYTE_W-1:0];
        end
        n = 0;
        for (b = 0; b < ALPHABET_SIZE; b++)
            n += opens_range(b);
        r.count = n[COUNT_W-1:0];
        return r;
    endfunction

    function automatic void queue_item(bit f, int first, int last, int probe);
        item_t it;
        it.func  = f;
        it.first = first[BYTE_W-1:0];
        it.last  = last[BYTE_W-1:0];
        it.probe = probe[BYTE_W-1:0];
        pending_items.insert(pending_items.size(), it);
    endfunction

    // Random beat: mostly lookups, inserts of bounded width, a few reversed
    function automatic void queue_random_item(int insert_pct, int max_width);
        int a;
        int z;
        if ($urandom_range(99) >= insert_pct)
            queue_item(FUNC_LOOKUP, $urandom_range(255), $urandom_range(255),
                       $urandom_range(255));
        else if ($urandom_range(9) == 0)
        begin
            a = $urandom_range(255, 1);
            z = $urandom_range(a - 1);
            queue_item(FUNC_INSERT, a, z, $urandom_range(255));
        end
        else
        begin
            a = $urandom_range(255);
            z = a + $urandom_range(max_width);
            if (z > TOP_BYTE)
                z = TOP_BYTE;
            queue_item(FUNC_INSERT, a, z, $urandom_range(255));
        end
    endfunction

    function automatic void set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endfunction

    // Hold the sender back until every queued beat has its result
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_classes.size() != 0)
            @(posedge clk);
    endtask

    // Driver: hold a stalled beat, otherwise offer the next one or idle
    always @(negedge clk)
    begin : item_driver
        item_t nxt;
        if (!rst_n || (in_valid && !in_fire))
        begin
        end
        else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            nxt = pending_items.pop_front();
            in_valid    <= 1'b1;
            func        <= nxt.func;
            range_first <= nxt.first;
            range_last  <= nxt.last;
            probe_byte  <= nxt.probe;
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver stall: long hold-off or random back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= out_hold || ($urandom_range(99) < recv_stall_pct);
    end

    // Long hold-off, counted in its own process
    initial
    begin
        wait (hold_go);
        out_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold = 1'b0;
    end

    // Monitor: predict on input beats, check output beats
    always @(posedge clk)
    begin : beat_monitor
        item_t         it;
        class_result_t want;
        class_result_t got;
        in_fire <= in_valid && !in_stall;
        if (in_valid && in_stall)
            in_stall_cycles++;
        if (in_valid && !in_stall)
        begin
            it = '{func: func, first: range_first, last: range_last, probe: probe_byte};
            expected_classes.insert(expected_classes.size(), partition_step(it));
        end
        if (out_valid && !out_stall)
        begin
            got = '{bad: bad_range, covered: probe_covered, index: class_index,
                    lo: class_first, hi: class_last, count: range_count};
            if (expected_classes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result beat with none expected: %p", $realtime, got);
            end
            else
            begin
                want = expected_classes.pop_front();
                checked_beats++;
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: result beat %0d differs", $realtime, checked_beats);
                        $display("  bad      exp %0d act %0d", want.bad, got.bad);
                        $display("  covered  exp %0d act %0d", want.covered, got.covered);
                        $display("  index    exp %0d act %0d", want.index, got.index);
                        $display("  first    exp %0d act %0d", want.lo, got.lo);
                        $display("  last     exp %0d act %0d", want.hi, got.hi);
                        $display("  count    exp %0d act %0d", want.count, got.count);
                    end
                end
                if (want.bad)
                    reversed_beats++;
                if (want.covered)
                    covered_hits++;
                if (want.count > peak_count)
                    peak_count = want.count;
            end
        end
    end

    // Count beat kinds as they are taken
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            if (func == FUNC_INSERT)
                insert_beats++;
            else
                lookup_beats++;
        end
    end

    // Stimulus sequence
    initial
    begin : stimulus
        int         widths[6];
        int         p;
        int         i;
        int         j;
        logic [7:0] order[ALPHABET_SIZE];
        logic [7:0] swap;

        widths = '{3, 15, 1, 63, 7, 255};
        covered_bytes = '0;
        cut_bytes     = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners, no idling
        set_idling(0, 0);
        queue_item(FUNC_LOOKUP, 0, 0, 0);
        queue_item(FUNC_LOOKUP, 255, 255, 255);
        queue_item(FUNC_INSERT, 200, 100, 0);
        queue_item(FUNC_INSERT, 255, 0, 255);
        queue_item(FUNC_INSERT, 10, 20, 0);
        queue_item(FUNC_INSERT, 21, 30, 0);
        queue_item(FUNC_LOOKUP, 0, 0, 21);
        queue_item(FUNC_LOOKUP, 0, 0, 20);
        queue_item(FUNC_INSERT, 15, 25, 0);
        queue_item(FUNC_LOOKUP, 0, 0, 18);
        queue_item(FUNC_LOOKUP, 0, 0, 22);
        queue_item(FUNC_LOOKUP, 0, 0, 26);
        queue_item(FUNC_INSERT, 0, 0, 0);
        queue_item(FUNC_INSERT, 255, 255, 0);
        queue_item(FUNC_LOOKUP, 0, 0, 0);
        queue_item(FUNC_LOOKUP, 0, 0, 255);
        queue_item(FUNC_LOOKUP, 0, 0, 5);
        queue_item(FUNC_INSERT, 40, 40, 0);
        queue_item(FUNC_LOOKUP, 0, 0, 40);
        queue_item(FUNC_INSERT, 100, 200, 0);
        queue_item(FUNC_LOOKUP, 0, 0, 150);
        queue_item(FUNC_INSERT, 250, 255, 0);
        queue_item(FUNC_LOOKUP, 0, 0, 253);
        queue_item(FUNC_LOOKUP, 0, 0, 249);
        wait_drained();

        // Random phases, cycling through the idling patterns
        for (p = 0; p < 6; p++)
        begin
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(81, 0);
                2: set_idling(0, 81);
                default: set_idling(9, 9);
            endcase
            for (i = 0; i < 200; i++)
                queue_random_item(15, widths[p]);
            wait_drained();
        end

        // Long output hold-off while the sender keeps offering beats
        set_idling(0, 0);
        for (i = 0; i < 60; i++)
            queue_random_item(20, 7);
        hold_go = 1'b1;
        wait_drained();

        // Cut the alphabet into single bytes in shuffled order
        set_idling(9, 9);
        for (i = 0; i < ALPHABET_SIZE; i++)
            order[i] = i[7:0];
        for (i = ALPHABET_SIZE - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (i = 0; i < ALPHABET_SIZE; i++)
        begin
            queue_item(FUNC_INSERT, order[i], order[i], $urandom_range(255));
            if (i % 4 == 3)
                queue_item(FUNC_LOOKUP, $urandom_range(255), $urandom_range(255),
                           $urandom_range(255));
        end
        wait_drained();

        // Let any stray beat surface, then report
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_classes.size() != 0)
            mismatch_count++;
        $display("Run covered %0d inserts (%0d reversed) and %0d lookups (%0d covered).",
                 insert_beats, reversed_beats, lookup_beats, covered_hits);
        $display("Highest range count %0d; input held off for %0d cycles.",
                 peak_count, in_stall_cycles);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
rtl/brp_pkg.sv
rtl/brp_front.sv
rtl/brp_back.sv
rtl/byte_range_partitioner.sv
tb/byte_range_partitioner_tb.sv
